[rtl/wcpu_pkg.sv]
// shared types, constants and a flags helper for the word cpu
`timescale 1ns / 1ps

package wcpu_pkg;

  localparam int unsigned MemWordsDefault = 65536;
  localparam logic [15:0] ResetPcDefault = 16'h1000;

  // item actions
  localparam logic [1:0] ActExec   = 2'd0;
  localparam logic [1:0] ActMemWr  = 2'd1;
  localparam logic [1:0] ActMemRd  = 2'd2;
  localparam logic [1:0] ActRegRd  = 2'd3;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] address;
    logic [15:0] write_data;
    logic [2:0]  reg_index;
  } in_item_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic [15:0] program_counter;
    logic        sign_flag;
    logic        zero_flag;
    logic        overflow_flag;
    logic        carry_flag;
    logic        interrupts_on;
    logic        stopped;
    logic        prefix_pending;
  } out_item_t;

  typedef struct packed {
    logic s;
    logic z;
    logic o;
    logic c;
  } flags_t;

  // memory address source chosen by the controller
  typedef enum logic [2:0] {
    ASEL_PC,
    ASEL_ITEM,
    ASEL_REG,
    ASEL_REG_DEC,
    ASEL_WORD
  } addr_sel_t;

  // controller to datapath
  typedef struct packed {
    logic        mem_rd;
    logic        mem_wr;
    addr_sel_t   asel;
    logic [2:0]  areg;
    logic        pc_inc;
    logic        latch_op;
    logic        latch_w1;
    logic        latch_lo;
    logic        reg_inc;
    logic        reg_dec;
    logic        exec_simple;
    logic        exec_jump;
    logic        exec_branch;
    logic        exec_mem;
    logic        mem_dbl;
    logic        clr_sdbd;
    logic        item_wr;
    logic        take_result;
    logic        res_mem;
    logic        res_reg;
    logic        clr_wr;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [9:0] op;
    logic       halted;
    logic       sdbd;
    logic       clr_last;
  } dp_stat_t;

  function automatic logic [15:0] flags_word(input flags_t f);
    logic [7:0] b;
    b = {f.s, f.z, f.o, f.c, 4'b0000};
    return {b, b};
  endfunction

endpackage

[rtl/wcpu_ram.sv]
// generic single port ram with registered read
`timescale 1ns / 1ps

module wcpu_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // registered read of the old contents on a write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[rtl/wcpu_datapath.sv]
// register file, flags, alu and memory port of the word cpu
`timescale 1ns / 1ps

module wcpu_datapath #(
  parameter int unsigned MemWords = wcpu_pkg::MemWordsDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_data,
  input  wcpu_pkg::in_item_t  item,
  input  wcpu_pkg::dp_cmd_t   cmd,
  output wcpu_pkg::dp_stat_t  stat,
  output wcpu_pkg::out_item_t result
);

  localparam int unsigned AW = $clog2(MemWords);

  logic [15:0]      regs [8];
  wcpu_pkg::flags_t flags;
  logic             ie;
  logic             sdbd;
  logic             halted;
  logic [9:0]       op;
  logic [15:0]      w1;
  logic [7:0]       lo_byte;
  logic [15:0]      base;
  logic [15:0]      mem_rdata;
  logic [15:0]      mem_addr16;
  logic [15:0]      mem_wdata;
  logic [AW-1:0]    mem_addr;
  logic [AW-1:0]    clr_addr;
  logic             ram_we;
  logic [AW-1:0]    ram_addr;
  logic [15:0]      ram_wdata;

  // memory address select
  always_comb begin
    case (cmd.asel)
      wcpu_pkg::ASEL_PC:      mem_addr16 = regs[7];
      wcpu_pkg::ASEL_ITEM:    mem_addr16 = item.address;
      wcpu_pkg::ASEL_REG:     mem_addr16 = regs[cmd.areg];
      wcpu_pkg::ASEL_REG_DEC: mem_addr16 = regs[cmd.areg] - 16'd1;
      wcpu_pkg::ASEL_WORD:    mem_addr16 = mem_rdata;
      default:                mem_addr16 = regs[7];
    endcase
    mem_wdata = (cmd.asel == wcpu_pkg::ASEL_ITEM) ? item.write_data : regs[op[2:0]];
  end

  assign mem_addr = mem_addr16[AW-1:0];

  // clearing pass after reset walks every address once
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_wr) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  assign ram_we    = cmd.mem_wr | cmd.clr_wr;
  assign ram_addr  = cmd.clr_wr ? clr_addr : mem_addr;
  assign ram_wdata = cmd.clr_wr ? 16'd0 : mem_wdata;

  wcpu_ram #(.Width(16), .Depth(MemWords)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (mem_rdata)
  );

  assign stat.op       = op;
  assign stat.halted   = halted;
  assign stat.sdbd     = sdbd;
  assign stat.clr_last = (clr_addr == AW'(MemWords - 1));

  // combinational execution of the current step
  logic [15:0]      r_n [8];
  wcpu_pkg::flags_t f_n;
  logic             ie_n;
  logic             sdbd_n;
  logic             halt_n;
  logic [15:0]      a;
  logic [15:0]      b;
  logic [16:0]      sum;
  logic [15:0]      res;
  logic [15:0]      v;
  logic [15:0]      val;
  logic             t;
  logic [2:0]       rg;
  logic [2:0]       md;
  logic [1:0]       rr;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      r_n[i] = regs[i];
    end
    f_n    = flags;
    ie_n   = ie;
    sdbd_n = sdbd;
    halt_n = halted;
    a      = '0;
    b      = '0;
    sum    = '0;
    res    = '0;
    v      = regs[{1'b0, op[1:0]}];
    val    = cmd.mem_dbl ? {mem_rdata[7:0], lo_byte} : mem_rdata;
    t      = 1'b0;
    rg     = op[2:0];
    md     = op[5:3];
    rr     = w1[9:8];

    if (cmd.pc_inc) begin
      r_n[7] = regs[7] + 16'd1;
    end
    if (cmd.reg_inc) begin
      r_n[cmd.areg] = regs[cmd.areg] + 16'd1;
    end
    if (cmd.reg_dec) begin
      r_n[cmd.areg] = regs[cmd.areg] - 16'd1;
    end
    if (cmd.clr_sdbd) begin
      sdbd_n = 1'b0;
    end

    if (cmd.exec_simple) begin
      if (op < 10'h040) begin
        // control and single register
        if (op == 10'h000) begin
          halt_n = 1'b1;
        end else if (op == 10'h001) begin
          sdbd_n = 1'b1;
        end else if (op == 10'h002) begin
          ie_n = 1'b1;
        end else if (op == 10'h003) begin
          ie_n = 1'b0;
        end else if (op == 10'h006) begin
          f_n.c = 1'b0;
        end else if (op == 10'h007) begin
          f_n.c = 1'b1;
        end else if (op < 10'h010 && op >= 10'h008) begin
          res = regs[rg] + 16'd1;
          r_n[rg] = res;
          f_n.s = res[15];
          f_n.z = (res == '0);
        end else if (op >= 10'h010 && op < 10'h018) begin
          res = regs[rg] - 16'd1;
          r_n[rg] = res;
          f_n.s = res[15];
          f_n.z = (res == '0);
        end else if (op >= 10'h018 && op < 10'h020) begin
          res = ~regs[rg];
          r_n[rg] = res;
          f_n.s = res[15];
          f_n.z = (res == '0);
        end else if (op >= 10'h020 && op < 10'h028) begin
          b = regs[rg];
          res = 16'd0 - b;
          f_n.c = (b == '0);
          f_n.o = b[15] & res[15];
          f_n.s = res[15];
          f_n.z = (res == '0);
          r_n[rg] = res;
        end else if (op >= 10'h028 && op < 10'h030) begin
          a = regs[rg];
          sum = {1'b0, a} + {16'd0, flags.c};
          res = sum[15:0];
          f_n.c = sum[16];
          f_n.o = ~a[15] & res[15];
          f_n.s = res[15];
          f_n.z = (res == '0);
          r_n[rg] = res;
        end else if (op >= 10'h030 && op < 10'h034) begin
          r_n[{1'b0, op[1:0]}] = wcpu_pkg::flags_word(flags);
        end else if (op >= 10'h038) begin
          f_n.s = regs[rg][7];
          f_n.z = regs[rg][6];
          f_n.o = regs[rg][5];
          f_n.c = regs[rg][4];
        end
      end else if (op < 10'h080) begin
        // shifts and rotates
        unique case (op[5:3])
          3'd0: begin
            res = op[2] ? {v[7:0], v[7:0]} : {v[7:0], v[15:8]};
            f_n.s = res[7];
          end
          3'd1: begin
            res = op[2] ? {v[13:0], 2'b00} : {v[14:0], 1'b0};
            f_n.s = res[15];
          end
          3'd2: begin
            res = op[2] ? {v[13:0], flags.c, flags.o} : {v[14:0], flags.c};
            if (op[2]) f_n.o = v[14];
            f_n.c = v[15];
            f_n.s = res[15];
          end
          3'd3: begin
            res = op[2] ? {v[13:0], 2'b00} : {v[14:0], 1'b0};
            f_n.c = v[15];
            if (op[2]) f_n.o = v[14];
            f_n.s = res[15];
          end
          3'd4: begin
            res = op[2] ? {2'b00, v[15:2]} : {1'b0, v[15:1]};
            f_n.s = res[7];
          end
          3'd5: begin
            res = op[2] ? {{2{v[15]}}, v[15:2]} : {v[15], v[15:1]};
            f_n.s = res[7];
          end
          3'd6: begin
            if (op[2]) begin
              res = {flags.c, flags.o, v[15:2]};
              f_n.c = v[1];
              f_n.o = v[0];
            end else begin
              res = {flags.c, v[15:1]};
              f_n.c = v[0];
            end
            f_n.s = res[7];
          end
          default: begin
            res = op[2] ? {{2{v[15]}}, v[15:2]} : {v[15], v[15:1]};
            if (op[2]) begin
              f_n.c = v[1];
              f_n.o = v[0];
            end else begin
              f_n.c = v[0];
            end
            f_n.s = res[7];
          end
        endcase
        f_n.z = (res == '0);
        r_n[{1'b0, op[1:0]}] = res;
      end else begin
        // register to register
        a = regs[rg];
        b = regs[md];
        unique case (op[8:6])
          3'd2: begin
            res = b;
            r_n[rg] = res;
          end
          3'd3: begin
            sum = {1'b0, a} + {1'b0, b};
            res = sum[15:0];
            f_n.c = sum[16];
            f_n.o = ~(a[15] ^ b[15]) & (a[15] ^ res[15]);
            r_n[rg] = res;
          end
          3'd4, 3'd5: begin
            res = a - b;
            f_n.c = (a >= b);
            f_n.o = (a[15] ^ b[15]) & (a[15] ^ res[15]);
            if (op[8:6] == 3'd4) r_n[rg] = res;
          end
          3'd6: begin
            res = a & b;
            r_n[rg] = res;
          end
          default: begin
            res = a ^ b;
            r_n[rg] = res;
          end
        endcase
        f_n.s = res[15];
        f_n.z = (res == '0);
      end
    end

    if (cmd.exec_jump) begin
      // second jump word arrives in mem_rdata, pc already past both words
      if (w1[1:0] == 2'd1) ie_n = 1'b1;
      else if (w1[1:0] == 2'd2) ie_n = 1'b0;
      if (rr != 2'd3) r_n[{1'b1, rr}] = regs[7];
      r_n[7] = {w1[7:2], mem_rdata[9:0]};
    end

    if (cmd.exec_branch) begin
      unique case (op[2:0])
        3'd0:    t = 1'b1;
        3'd1:    t = flags.c;
        3'd2:    t = flags.o;
        3'd3:    t = ~flags.s;
        3'd4:    t = flags.z;
        3'd5:    t = flags.s ^ flags.o;
        3'd6:    t = flags.z | (flags.s ^ flags.o);
        default: t = flags.c ^ flags.s;
      endcase
      t = op[3] ? ~t : t;
      if (!op[4] && t) begin
        r_n[7] = op[5] ? base + 16'd1 - mem_rdata : base + 16'd2 + mem_rdata;
      end
    end

    if (cmd.exec_mem) begin
      a = regs[rg];
      unique case (op[9:6])
        4'd10: begin
          res = val;
          r_n[rg] = res;
        end
        4'd11: begin
          sum = {1'b0, a} + {1'b0, val};
          res = sum[15:0];
          f_n.c = sum[16];
          f_n.o = ~(a[15] ^ val[15]) & (a[15] ^ res[15]);
          f_n.s = res[15];
          f_n.z = (res == '0);
          r_n[rg] = res;
        end
        4'd12, 4'd13: begin
          res = a - val;
          f_n.c = (a >= val);
          f_n.o = (a[15] ^ val[15]) & (a[15] ^ res[15]);
          f_n.s = res[15];
          f_n.z = (res == '0);
          if (op[9:6] == 4'd12) r_n[rg] = res;
        end
        4'd14: begin
          res = a & val;
          f_n.s = res[15];
          f_n.z = (res == '0);
          r_n[rg] = res;
        end
        default: begin
          res = a ^ val;
          f_n.s = res[15];
          f_n.z = (res == '0);
          r_n[rg] = res;
        end
      endcase
    end

    if (cfg_we) begin
      r_n[7] = cfg_data;
    end
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 7; i++) begin
        regs[i] <= '0;
      end
      regs[7] <= wcpu_pkg::ResetPcDefault;
      flags   <= '0;
      ie      <= 1'b0;
      sdbd    <= 1'b0;
      halted  <= 1'b0;
    end else begin
      for (int i = 0; i < 8; i++) begin
        regs[i] <= r_n[i];
      end
      flags  <= f_n;
      ie     <= ie_n;
      sdbd   <= sdbd_n;
      halted <= halt_n;
    end
  end

  // instruction latches and result register
  always_ff @(posedge clk) begin
    if (cmd.latch_op) begin
      op   <= mem_rdata[9:0];
      base <= regs[7] - 16'd1;
    end
    if (cmd.latch_w1) begin
      w1 <= mem_rdata;
    end
    if (cmd.latch_lo) begin
      lo_byte <= mem_rdata[7:0];
    end
    if (cmd.take_result) begin
      result.read_data <= cmd.res_reg ? regs[item.reg_index] :
                          cmd.res_mem ? mem_rdata : 16'd0;
      result.program_counter <= r_n[7];
      result.sign_flag       <= f_n.s;
      result.zero_flag       <= f_n.z;
      result.overflow_flag   <= f_n.o;
      result.carry_flag      <= f_n.c;
      result.interrupts_on   <= ie_n;
      result.stopped         <= halt_n;
      result.prefix_pending  <= sdbd_n;
    end
  end

endmodule

[rtl/wcpu_ctrl.sv]
// sequencing state machine of the word cpu
`timescale 1ns / 1ps

module wcpu_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  wcpu_pkg::in_item_t item,
  output logic               out_valid,
  input  logic               out_ready,
  input  wcpu_pkg::dp_stat_t stat,
  output wcpu_pkg::dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MEMRD,
    S_FETCH,
    S_DECODE,
    S_JMP2,
    S_BRANCH,
    S_DIRADDR,
    S_DIRDATA,
    S_IND1,
    S_IND2,
    S_DONE
  } state_t;

  state_t     state;
  logic       busy;
  logic [9:0] op;
  logic [2:0] md;
  logic       dbl;
  logic       out_free;

  assign op       = stat.op;
  assign md       = op[5:3];
  assign busy     = (state != S_IDLE);
  assign out_free = !out_valid || out_ready;
  assign in_ready = !busy && out_free;

  // commands for each state
  always_comb begin
    cmd      = '0;
    cmd.asel = wcpu_pkg::ASEL_PC;
    cmd.areg = md;
    unique case (state)
      S_CLEAR: cmd.clr_wr = 1'b1;
      S_IDLE: begin
        if (in_valid && in_ready) begin
          unique case (item.action)
            wcpu_pkg::ActExec: begin
              if (stat.halted) begin
                cmd.take_result = 1'b1;
              end else begin
                cmd.mem_rd = 1'b1;
                cmd.pc_inc = 1'b1;
              end
            end
            wcpu_pkg::ActMemWr: begin
              cmd.asel        = wcpu_pkg::ASEL_ITEM;
              cmd.mem_wr      = 1'b1;
              cmd.take_result = 1'b1;
            end
            wcpu_pkg::ActMemRd: begin
              cmd.asel   = wcpu_pkg::ASEL_ITEM;
              cmd.mem_rd = 1'b1;
            end
            default: begin
              cmd.res_reg     = 1'b1;
              cmd.take_result = 1'b1;
            end
          endcase
        end
      end
      S_MEMRD: begin
        cmd.res_mem     = 1'b1;
        cmd.take_result = 1'b1;
      end
      S_FETCH: cmd.latch_op = 1'b1;
      S_DECODE: begin
        cmd.clr_sdbd = 1'b1;
        if (op == 10'h004) begin
          cmd.mem_rd = 1'b1;
          cmd.pc_inc = 1'b1;
        end else if (op < 10'h200) begin
          cmd.exec_simple = 1'b1;
          cmd.take_result = 1'b1;
        end else if (op < 10'h240) begin
          cmd.mem_rd = 1'b1;
          cmd.pc_inc = 1'b1;
        end else if (op[9:6] == 4'd9) begin
          // store
          if (md == 3'd0) begin
            cmd.mem_rd = 1'b1;
            cmd.pc_inc = 1'b1;
          end else begin
            cmd.asel        = wcpu_pkg::ASEL_REG;
            cmd.mem_wr      = 1'b1;
            cmd.reg_inc     = md[2];
            cmd.take_result = 1'b1;
          end
        end else if (md == 3'd0) begin
          cmd.mem_rd = 1'b1;
          cmd.pc_inc = 1'b1;
        end else if (md == 3'd6) begin
          cmd.asel    = wcpu_pkg::ASEL_REG_DEC;
          cmd.mem_rd  = 1'b1;
          cmd.reg_dec = 1'b1;
        end else begin
          cmd.asel    = wcpu_pkg::ASEL_REG;
          cmd.mem_rd  = 1'b1;
          cmd.reg_inc = md[2];
        end
      end
      S_JMP2: begin
        cmd.latch_w1 = 1'b1;
        cmd.mem_rd   = 1'b1;
        cmd.pc_inc   = 1'b1;
      end
      S_BRANCH: begin
        if (op == 10'h004) cmd.exec_jump = 1'b1;
        else cmd.exec_branch = 1'b1;
        cmd.take_result = 1'b1;
      end
      S_DIRADDR: begin
        cmd.asel   = wcpu_pkg::ASEL_WORD;
        cmd.mem_rd = (op[9:6] != 4'd9);
        cmd.mem_wr = (op[9:6] == 4'd9);
        cmd.take_result = (op[9:6] == 4'd9);
      end
      S_DIRDATA: begin
        cmd.exec_mem    = 1'b1;
        cmd.take_result = 1'b1;
      end
      S_IND1: begin
        if (dbl) begin
          cmd.latch_lo = 1'b1;
          cmd.mem_rd   = 1'b1;
          if (md == 3'd6) begin
            cmd.asel    = wcpu_pkg::ASEL_REG_DEC;
            cmd.reg_dec = 1'b1;
          end else begin
            cmd.asel    = wcpu_pkg::ASEL_REG;
            cmd.reg_inc = md[2];
          end
        end else begin
          cmd.exec_mem    = 1'b1;
          cmd.take_result = 1'b1;
        end
      end
      S_IND2: begin
        cmd.mem_dbl     = 1'b1;
        cmd.exec_mem    = 1'b1;
        cmd.take_result = 1'b1;
      end
      default: ;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
      dbl       <= 1'b0;
    end else begin
      out_valid <= cmd.take_result || (out_valid && !out_ready);
      unique case (state)
        S_CLEAR: begin
          if (stat.clr_last) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid && in_ready) begin
            if (item.action == wcpu_pkg::ActMemRd) state <= S_MEMRD;
            else if (item.action == wcpu_pkg::ActExec && !stat.halted) state <= S_FETCH;
          end
        end
        S_MEMRD: state <= S_IDLE;
        S_FETCH: begin
          state <= S_DECODE;
          dbl   <= stat.sdbd;
        end
        S_DECODE: begin
          if (op == 10'h004) state <= S_JMP2;
          else if (op < 10'h200) state <= S_IDLE;
          else if (op < 10'h240) state <= S_BRANCH;
          else if (md == 3'd0) state <= S_DIRADDR;
          else if (op[9:6] == 4'd9) state <= S_IDLE;
          else state <= S_IND1;
        end
        S_JMP2:    state <= S_BRANCH;
        S_BRANCH:  state <= S_IDLE;
        S_DIRADDR: state <= (op[9:6] == 4'd9) ? S_IDLE : S_DIRDATA;
        S_DIRDATA: state <= S_IDLE;
        S_IND1:    state <= dbl ? S_IND2 : S_IDLE;
        S_IND2:    state <= S_IDLE;
        default:   state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  // a result is produced only by a busy step or an accepted item
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    cmd.take_result |-> busy || (in_valid && in_ready))
    else $error("result without an item");

  // never read and write memory in the same step
  a_mem_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.mem_rd && cmd.mem_wr))
    else $error("memory read and write together");

  // no result overwrites one not yet taken
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    cmd.take_result |-> !out_valid || out_ready)
    else $error("result overrun");

  // fetch is always followed by decode
  a_fetch_decode: assert property (@(posedge clk) disable iff (rst)
    state == S_FETCH |=> state == S_DECODE)
    else $error("fetch not followed by decode");
`endif

endmodule

[rtl/word_cpu_instruction_executor.sv]
// top level of the word cpu instruction executor
`timescale 1ns / 1ps

// A 16-bit word cpu with a local word memory. Each transfer on the input
// channel either executes one instruction or reads or writes memory or
// reads a register, and gives exactly one result transfer. After reset the
// block clears the memory before it takes the first item. The steps of an
// instruction are set by the sequence of accesses to the single memory port
// (fetch, extra instruction words, operand reads). An execute item while
// stopped gives its result without fetching an instruction. The next item
// is taken once the previous result has left or is leaving. A write on
// cfg_we loads cfg_data into R7.

module word_cpu_instruction_executor #(
  parameter int unsigned MemWords = wcpu_pkg::MemWordsDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  wcpu_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output wcpu_pkg::out_item_t out_data
);

  wcpu_pkg::dp_cmd_t  cmd;
  wcpu_pkg::dp_stat_t stat;

  // sequencer
  wcpu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .item      (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath
  wcpu_datapath #(.MemWords(MemWords)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .item     (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .result   (out_data)
  );

endmodule
